### rtl/stick_slip_bow_friction_assert.svh
// Assertion macros shared by the bow friction RTL.
// Every check samples on clk_i and is off while rst_ni is low.
`ifndef STICK_SLIP_BOW_FRICTION_ASSERT_SVH
`define STICK_SLIP_BOW_FRICTION_ASSERT_SVH

// Plain property check.
`define SSBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ssbf check failed");

// Same-cycle implication check.
`define SSBF_ASSERT_IMP(lbl, ante, cons) \
  `SSBF_ASSERT(lbl, (ante) |-> (cons))

`endif

### rtl/ssbf_pkg.sv
`timescale 1ns / 1ps

package ssbf_pkg;

  // Field widths
  localparam int DATA_W     = 32;
  localparam int PRESS_W    = 31;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;

  // Digit-serial adders: operands extended so sums never wrap
  localparam int DIGIT_W    = 4;
  localparam int EXT_W      = 36;
  localparam int NUM_DIGITS = EXT_W / DIGIT_W;

  // Divider: quotient never exceeds press_force, denominator below 2^33
  localparam int QUOT_W     = PRESS_W;
  localparam int DEN_W      = 33;
  localparam int NUM_SPLIT  = QUOT_W - FRAC_W;
  localparam int CNT_W      = 5;

  // 1.0 in Q16.16, added to |relative velocity|
  localparam logic [EXT_W-1:0] DENOM_BIAS =
    {{(EXT_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOW_SPEED   = 2'd0,
    CFG_PRESS_FORCE = 2'd1,
    CFG_ENABLED     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD1,
    ST_SETUP2,
    ST_ADD2,
    ST_SETUP_DIV,
    ST_DIV,
    ST_EMIT
  } state_e;

  // What a tick has to compute
  typedef enum logic [1:0] {
    KIND_STICK,
    KIND_SNAP,
    KIND_SLIP
  } kind_e;

  function automatic logic [EXT_W-1:0] sext_ext(input logic [DATA_W-1:0] v);
    return {{(EXT_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // Clamp an extended sum to the signed 32-bit range
  function automatic logic [DATA_W-1:0] sat_data(input logic [EXT_W-1:0] v);
    logic [EXT_W-DATA_W:0] top;
    top = v[EXT_W-1:DATA_W-1];
    if ((&top) || (~|top)) begin
      return v[DATA_W-1:0];
    end else if (v[EXT_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/ssbf_if.sv
`timescale 1ns / 1ps

// Tick input channel
interface ssbf_in_if import ssbf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] cell_velocity;
  logic signed [DATA_W-1:0] cell_position;

  modport source (output valid, output cell_velocity, output cell_position, input ready);
  modport sink   (input valid, input cell_velocity, input cell_position, output ready);
endinterface

// Force result channel
interface ssbf_out_if import ssbf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] applied_force;
  logic                     slipping;

  modport source (output valid, output applied_force, output slipping, input ready);
  modport sink   (input valid, input applied_force, input slipping, output ready);
endinterface

// Register write channel
interface ssbf_cfg_if import ssbf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [DATA_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/stick_slip_bow_friction.sv
`timescale 1ns / 1ps
// Channel | Dir | Word
// in_i    | in  | cell_velocity, cell_position (signed Q16.16)
// out_o   | out | applied_force (signed Q16.16), slipping
// cfg_i   | in  | reg_index, wdata (always ready)
// A disabled tick is only accepted; a slip tick that returns to stick goes straight to the
// result, a stick tick runs both add passes, and a slip tick that divides adds the divider.
// The two 9-digit serial add passes (4 bits a cycle) and the 31-step restoring
// divider do the arithmetic; a new tick is taken only once the last one is done.
// A result waits in the output register while the next tick is taken and worked on.
// Reset puts the block in stick mode with zero position and force, ready at once.

module stick_slip_bow_friction import ssbf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ssbf_in_if.sink   in_i,
  ssbf_out_if.source out_o,
  ssbf_cfg_if.sink  cfg_i
);

  // Configuration registers
  logic [DATA_W-1:0]  bow_speed_q;
  logic [PRESS_W-1:0] press_force_q;
  logic               enabled_q;

  // Tick state
  state_e             state_q, state_d;
  kind_e              kind_q, kind_d;
  logic [CNT_W-1:0]   cnt_q;
  logic               slip_q;
  logic [DATA_W-1:0]  bow_pos_q;
  logic [DATA_W-1:0]  held_q;

  // Captured input word
  logic [DATA_W-1:0]  cell_pos_q;

  // Two digit-serial adders
  logic [EXT_W-1:0]   a1_q, b1_q, r1_q;
  logic [EXT_W-1:0]   a2_q, b2_q, r2_q;
  logic               c1_q, c2_q;
  logic [DIGIT_W:0]   s1, s2;

  // Restoring divider
  logic [DEN_W-1:0]   rem_q, denom_q, rem_n;
  logic [QUOT_W-1:0]  num_q, quot_q;
  logic [DEN_W+1:0]   trial;
  logic [DEN_W:0]     rem_shift;
  logic               div_ge;

  // Result path
  logic [DATA_W-1:0]  out_force_q;
  logic               out_slip_q;
  logic               out_valid_q;
  logic               out_free;
  logic [DATA_W-1:0]  stick_force;
  logic               over_press;
  logic               slip_n;
  logic [DATA_W-1:0]  held_n;

  // Control strobes
  logic               in_fire;
  logic               tick_start;
  logic               digit_last;
  logic               div_last;
  logic               emit_fire;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bow_speed_q   <= '0;
      press_force_q <= PRESS_W'(1) << FRAC_W;
      enabled_q     <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.reg_index))
        CFG_BOW_SPEED:   bow_speed_q   <= cfg_i.wdata;
        CFG_PRESS_FORCE: press_force_q <= cfg_i.wdata[PRESS_W-1:0];
        CFG_ENABLED:     enabled_q     <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake strobes
  assign in_fire    = in_i.valid && in_i.ready;
  assign tick_start = in_fire && enabled_q;
  assign out_free   = !out_valid_q || out_o.ready;
  assign digit_last = (cnt_q == CNT_W'(NUM_DIGITS - 1));
  assign div_last   = (cnt_q == CNT_W'(QUOT_W - 1));

  // Classify the tick from the current mode and the cell velocity sign
  always_comb begin
    if (!slip_q) begin
      kind_d = KIND_STICK;
    end else if (!in_i.cell_velocity[DATA_W-1]) begin
      kind_d = KIND_SNAP;
    end else begin
      kind_d = KIND_SLIP;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (tick_start) state_d = (kind_d == KIND_SNAP) ? ST_EMIT : ST_ADD1;
      ST_ADD1:      if (digit_last) state_d = ST_SETUP2;
      ST_SETUP2:    state_d = ST_ADD2;
      ST_ADD2:      if (digit_last) state_d = (kind_q == KIND_STICK) ? ST_EMIT : ST_SETUP_DIV;
      ST_SETUP_DIV: state_d = ST_DIV;
      ST_DIV:       if (div_last) state_d = ST_EMIT;
      ST_EMIT:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    emit_fire  = (state_q == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_STICK;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (tick_start) begin
        kind_q <= kind_d;
      end
      // Count digits and divider steps; clear between passes
      if (state_q == ST_ADD1 || state_q == ST_ADD2 || state_q == ST_DIV) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // One digit of each adder per cycle
  assign s1 = {1'b0, a1_q[DIGIT_W-1:0]} + {1'b0, b1_q[DIGIT_W-1:0]} + {{DIGIT_W{1'b0}}, c1_q};
  assign s2 = {1'b0, a2_q[DIGIT_W-1:0]} + {1'b0, b2_q[DIGIT_W-1:0]} + {{DIGIT_W{1'b0}}, c2_q};

  // One quotient bit per cycle
  assign rem_shift = {rem_q, num_q[QUOT_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, denom_q};
  assign div_ge    = !trial[DEN_W+1];
  assign rem_n     = div_ge ? trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        // Pass 1: bow_position + bow_speed, and bow_speed - cell_velocity
        if (tick_start) begin
          cell_pos_q <= in_i.cell_position;
          a1_q       <= sext_ext(bow_pos_q);
          b1_q       <= sext_ext(bow_speed_q);
          c1_q       <= 1'b0;
          a2_q       <= sext_ext(bow_speed_q);
          b2_q       <= ~sext_ext(in_i.cell_velocity);
          c2_q       <= 1'b1;
        end
      end
      ST_ADD1, ST_ADD2: begin
        a1_q <= a1_q >> DIGIT_W;
        b1_q <= b1_q >> DIGIT_W;
        r1_q <= {s1[DIGIT_W-1:0], r1_q[EXT_W-1:DIGIT_W]};
        c1_q <= s1[DIGIT_W];
        a2_q <= a2_q >> DIGIT_W;
        b2_q <= b2_q >> DIGIT_W;
        r2_q <= {s2[DIGIT_W-1:0], r2_q[EXT_W-1:DIGIT_W]};
        c2_q <= s2[DIGIT_W];
      end
      ST_SETUP2: begin
        // Pass 2: new position - cell_position, and |relative velocity| + 1.0
        a1_q <= sext_ext(sat_data(r1_q));
        b1_q <= ~sext_ext(cell_pos_q);
        c1_q <= 1'b1;
        a2_q <= r2_q ^ {EXT_W{r2_q[EXT_W-1]}};
        b2_q <= DENOM_BIAS;
        c2_q <= r2_q[EXT_W-1];
      end
      ST_SETUP_DIV: begin
        // Numerator is press_force << 16; its upper part seeds the remainder
        denom_q <= r2_q[DEN_W-1:0];
        rem_q   <= DEN_W'(press_force_q[PRESS_W-1:NUM_SPLIT]);
        num_q   <= {press_force_q[NUM_SPLIT-1:0], {FRAC_W{1'b0}}};
      end
      ST_DIV: begin
        rem_q  <= rem_n;
        num_q  <= num_q << 1;
        quot_q <= {quot_q[QUOT_W-2:0], div_ge};
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_force_q <= held_n;
          out_slip_q  <= slip_n;
        end
      end
      default: ;
    endcase
  end

  // Final mode and force of the tick
  assign stick_force = sat_data(r1_q);
  assign over_press  = $signed(stick_force) > $signed({1'b0, press_force_q});

  always_comb begin
    unique case (kind_q)
      KIND_STICK: begin
        slip_n = over_press;
        held_n = over_press ? held_q : stick_force;
      end
      KIND_SNAP: begin
        slip_n = 1'b0;
        held_n = held_q;
      end
      KIND_SLIP: begin
        slip_n = 1'b1;
        held_n = {1'b0, quot_q};
      end
      default: begin
        slip_n = slip_q;
        held_n = held_q;
      end
    endcase
  end

  // Bow state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slip_q    <= 1'b0;
      bow_pos_q <= '0;
      held_q    <= '0;
    end else begin
      if (state_q == ST_SETUP2) begin
        bow_pos_q <= sat_data(r1_q);
      end
      if (emit_fire) begin
        slip_q <= slip_n;
        held_q <= held_n;
        if (kind_q == KIND_SNAP) begin
          bow_pos_q <= cell_pos_q;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.applied_force = out_force_q;
  assign out_o.slipping      = out_slip_q;

  `include "stick_slip_bow_friction_assert.svh"

  `SSBF_ASSERT_IMP(a_div_kind, state_q == ST_DIV, kind_q == KIND_SLIP)
  `SSBF_ASSERT_IMP(a_div_rem, state_q == ST_DIV, rem_q < denom_q)
  `SSBF_ASSERT_IMP(a_div_denom, state_q == ST_DIV, denom_q >= DENOM_BIAS[DEN_W-1:0])
  `SSBF_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(state_q == ST_EMIT))

endmodule

### test/stick_slip_bow_friction_tb.sv
`timescale 1ns / 1ps

module stick_slip_bow_friction_tb;
  import ssbf_pkg::*;

  localparam longint UNIT = 64'sd65536;
  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct {
    logic signed [DATA_W-1:0] applied_force;
    logic                     slipping;
  } friction_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ssbf_in_if  in_if ();
  ssbf_out_if out_if ();
  ssbf_cfg_if cfg_if ();

  stick_slip_bow_friction dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Register copies, as written through the register channel
  logic signed [DATA_W-1:0] bow_speed_r   = '0;
  logic [PRESS_W-1:0]       press_force_r = PRESS_W'(UNIT);
  logic                     enabled_r     = 1'b1;

  // Bow state, tracked one accepted tick at a time
  logic                     slip_st    = 1'b0;
  logic signed [DATA_W-1:0] bow_pos    = '0;
  logic signed [DATA_W-1:0] held_force = '0;

  friction_t pending_forces [$];
  friction_t want;

  int send_idle_pct    = 0;
  int stall_pct        = 0;
  int ticks_sent       = 0;
  int forces_checked   = 0;
  int settings_applied = 0;
  int mismatches       = 0;
  int cycles           = 0;

  always #5 clk_i = ~clk_i;

  // Clamp a wide value to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] clamp_s32(input longint v);
    if (v > longint'(S_MAX)) return S_MAX;
    if (v < longint'(S_MIN)) return S_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_corner();
    case ($urandom_range(6))
      0: return S_MIN;
      1: return S_MAX;
      2: return 32'sh0000_0000;
      3: return 32'shFFFF_FFFF;
      4: return 32'sh0000_0001;
      5: return 32'sh0001_0000;
      default: return 32'shFFFF_0000;
    endcase
  endfunction

  // Advance the bow by one tick and queue the force word it gives
  task automatic advance_bow(input logic signed [DATA_W-1:0] vel,
                             input logic signed [DATA_W-1:0] pos);
    longint    stick_force;
    longint    rel;
    friction_t word;
    if (enabled_r) begin
      bow_pos = clamp_s32(longint'(bow_pos) + longint'(bow_speed_r));
      if (!slip_st) begin
        stick_force = clamp_s32(longint'(bow_pos) - longint'(pos));
        if (stick_force > longint'(press_force_r)) begin
          slip_st = 1'b1;
        end else begin
          held_force = stick_force[DATA_W-1:0];
        end
      end else if (vel >= 0) begin
        slip_st = 1'b0;
        bow_pos = pos;
      end else begin
        rel = longint'(bow_speed_r) - longint'(vel);
        if (rel < 0) rel = -rel;
        held_force = DATA_W'((longint'(press_force_r) * UNIT) / (UNIT + rel));
      end
      word.applied_force = held_force;
      word.slipping      = slip_st;
      pending_forces.push_back(word);
    end
  endtask

  // Send one tick word, with random idle cycles ahead of it
  task automatic send_tick(input logic signed [DATA_W-1:0] vel,
                           input logic signed [DATA_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.cell_velocity <= vel;
    in_if.cell_position <= pos;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    ticks_sent++;
    advance_bow(vel, pos);
  endtask

  // Hold the sender until every expected force word has come back
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_forces.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then give a disabled or final tick time to finish
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers, in index order
  task automatic apply_settings(input logic [DATA_W-1:0] speed_w,
                                input logic [DATA_W-1:0] press_w,
                                input logic [DATA_W-1:0] en_w);
    cfg_idx_e          idx [3];
    logic [DATA_W-1:0] val [3];
    idx = '{CFG_BOW_SPEED, CFG_PRESS_FORCE, CFG_ENABLED};
    val = '{speed_w, press_w, en_w};
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid     <= 1'b1;
      cfg_if.reg_index <= idx[i];
      cfg_if.wdata     <= val[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      case (idx[i])
        CFG_BOW_SPEED:   bow_speed_r   = val[i];
        CFG_PRESS_FORCE: press_force_r = val[i][PRESS_W-1:0];
        CFG_ENABLED:     enabled_r     = val[i][0];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
    settings_applied++;
  endtask

  // Reset settings: zero force, saturated stick force, slip divides, return to stick
  task automatic test_reset_state();
    send_tick(32'sh0000_0000, 32'sh0000_0000);
    send_tick(32'sh0000_0000, S_MIN);
    send_tick(S_MIN, S_MAX);
    send_tick(32'shFFFF_FFFF, 32'sh0000_0000);
    send_tick(32'sh0000_0000, 32'sh0000_0000);
  endtask

  // Stick force equal to the press force stays in stick, one more slips
  task automatic test_equal_force();
    settle();
    apply_settings(32'h0000_0000, 32'h0002_8000, 32'h0000_0001);
    send_tick(32'sh0000_0000, clamp_s32(longint'(bow_pos) - longint'(press_force_r)));
    send_tick(32'sh0000_0000, clamp_s32(longint'(bow_pos) - longint'(press_force_r) - 1));
    send_tick(32'shFFFD_0000, 32'sh0000_0000);
    send_tick(S_MAX, 32'sh0001_2345);
  endtask

  // Drive the bow position into both rails
  task automatic test_position_saturation();
    settle();
    apply_settings(S_MAX, 32'h7FFF_FFFF, 32'h0000_0001);
    send_tick(32'sh0000_0001, S_MIN);
    send_tick(32'shFFFF_FFFF, S_MIN);
    settle();
    apply_settings(S_MIN, 32'h0000_0000, 32'h0000_0001);
    send_tick(32'sh0000_0000, S_MAX);
    send_tick(32'sh0000_0000, S_MAX);
  endtask

  // Zero and full press force through the divider, smallest and largest divisor
  task automatic test_press_extremes();
    settle();
    apply_settings(S_MAX, 32'h0000_0000, 32'h0000_0001);
    send_tick(32'sh0000_0000, 32'shFFFD_0000);
    send_tick(32'shFFFF_FFFF, 32'sh0000_0000);
    settle();
    apply_settings(S_MIN, 32'hFFFF_FFFF, 32'h0000_0001);
    send_tick(S_MIN, 32'sh0000_0000);
    settle();
    apply_settings(S_MAX, 32'hFFFF_FFFF, 32'h0000_0001);
    send_tick(S_MIN, 32'sh0000_0000);
    send_tick(32'sh0000_0000, 32'sh0000_0000);
  endtask

  // Ticks while disabled give nothing and leave the bow alone
  task automatic test_disabled();
    settle();
    apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
    repeat (3) send_tick($urandom(), $urandom());
    settle();
    apply_settings(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
    send_tick(32'sh0000_0000, 32'sh0000_0000);
  endtask

  // Random ticks, mostly near the stick/slip boundary, new settings every 40
  task automatic test_random_traffic(input int idle_pct, input int stall, input int count);
    logic [DATA_W-1:0]        r;
    logic [DATA_W-1:0]        speed_w;
    logic [DATA_W-1:0]        press_w;
    logic [DATA_W-1:0]        en_w;
    logic signed [DATA_W-1:0] vel;
    logic signed [DATA_W-1:0] pos;
    int unsigned              pick;
    longint                   span;
    longint                   off;
    int                       iter;
    int                       counted;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    iter          = 0;
    counted       = 0;
    while (counted < count) begin
      if (iter % 40 == 0) begin
        settle();
        pick = $urandom_range(99);
        if (pick < 70) speed_w = int'($urandom_range(32'h0004_0000)) - 131072;
        else if (pick < 85) speed_w = $urandom();
        else speed_w = pick_corner();
        pick = $urandom_range(99);
        if (pick < 70) press_w = $urandom_range(32'h0004_0000);
        else if (pick < 85) press_w = $urandom();
        else press_w = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0000_0000;
        r    = $urandom();
        en_w = {r[DATA_W-1:1], ($urandom_range(99) < 85)};
        apply_settings(speed_w, press_w, en_w);
      end
      iter++;
      if ($urandom_range(99) < 2) hold_until_drained();
      pick = $urandom_range(99);
      if (pick < 60) begin
        if ($urandom_range(99) < 65) vel = -int'($urandom_range(32'h0004_0000, 1));
        else vel = int'($urandom_range(32'h0004_0000));
        span = longint'(press_force_r) * 2 + UNIT;
        if (span > 64'sh3FFF_FFFF) span = 64'sh3FFF_FFFF;
        off = longint'($urandom_range(32'(span * 2))) - span;
        pos = clamp_s32(longint'(bow_pos) + longint'(bow_speed_r) - off);
      end else if (pick < 85) begin
        vel = $urandom();
        pos = $urandom();
      end else begin
        vel = pick_corner();
        pos = pick_corner();
      end
      if (enabled_r) counted++;
      send_tick(vel, pos);
    end
  endtask

  // Stall the force channel at random
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted force word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_forces.size() == 0) begin
        $display("%0t: unexpected force word: force %0d slipping %0b", $time,
                 out_if.applied_force, out_if.slipping);
        mismatches++;
      end else begin
        want = pending_forces.pop_front();
        forces_checked++;
        if (out_if.applied_force !== want.applied_force) begin
          $display("%0t: applied_force mismatch: expected %0d actual %0d", $time,
                   want.applied_force, out_if.applied_force);
          mismatches++;
        end
        if (out_if.slipping !== want.slipping) begin
          $display("%0t: slipping mismatch: expected %0b actual %0b", $time,
                   want.slipping, out_if.slipping);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d force words outstanding", $time, pending_forces.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.cell_velocity <= '0;
    in_if.cell_position <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.reg_index    <= CFG_BOW_SPEED;
    cfg_if.wdata        <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_equal_force();
    test_position_saturation();
    test_press_extremes();
    test_disabled();
    test_random_traffic(0, 0, 150);
    test_random_traffic(78, 0, 150);
    test_random_traffic(0, 78, 150);
    test_random_traffic(31, 31, 150);

    settle();
    $display("Sent %0d ticks, checked %0d force words across %0d register settings",
             ticks_sent, forces_checked, settings_applied);
    $display("Covered stick, slip, return to stick, rails, press extremes and disabled ticks");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
